// ===== hw/rtl/u64da_pkg.sv =====
// Shared constants, types and control struct for the u64 to decimal ASCII converter.
package u64da_pkg;

    localparam int MAX_DIGITS  = 20;
    localparam int VALUE_WIDTH = 64;

    localparam int NUM_CELLS  = 20;
    localparam int IN_W       = 64;
    localparam int CHAR_W     = 6;
    localparam int COUNT_W    = 5;
    localparam int IDX_W      = $clog2(NUM_CELLS);
    localparam int BIT_CNT_W  = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [3:0]           bcd_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_COUNT = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

// ===== hw/rtl/u64da_cell.sv =====
// One BCD digit cell of the shift-and-add-3 conversion chain.
module u64da_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  u64da_pkg::cell_ctl_t ctl,
    input  logic                 carry_in,
    output logic                 carry_out,
    output u64da_pkg::bcd_t      digit
);

    u64da_pkg::bcd_t digit_reg;
    u64da_pkg::bcd_t digit_next;
    u64da_pkg::bcd_t adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        digit_next = digit_reg;
        if (ctl.clear)
        begin
            digit_next = '0;
        end
        else if (ctl.shift)
        begin
            digit_next = {adj[2:0], carry_in};
        end
    end

    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== hw/rtl/u64_to_decimal_ascii.sv =====
// Top level: unsigned binary to decimal ASCII digit stream converter.
//
// Usage:
//   A transaction is accepted at a rising edge where start is high and busy
//   is low; value is sampled at that edge.
//   The value is shifted MSB first into a row of 20 BCD digit cells, one bit
//   per cycle, until all VALUE_WIDTH bits have passed the bit-serial chain.
//   The ST_COUNT state then finds the digit count, after which one digit
//   per cycle is presented, most significant first, each for exactly one
//   cycle with strobe high. digit_count is valid on every digit, is_last
//   marks the least significant digit. Zero gives the single digit '0'.
//   busy stays high until the last digit has been presented; the next
//   transaction can be accepted in the cycle after the last digit.
//   The receiver cannot stall: each digit is taken in its strobe cycle.
//   Reset (rst_n low, asynchronous) returns to idle with busy low; no
//   result is pending after reset.
module u64_to_decimal_ascii
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [u64da_pkg::IN_W-1:0]         value,
    output logic                               strobe,
    output logic [u64da_pkg::CHAR_W-1:0]       digit_char,
    output logic [u64da_pkg::COUNT_W-1:0]      digit_count,
    output logic                               is_last
);

    u64da_pkg::state_t   state_reg;
    u64da_pkg::state_t   state_next;
    logic [u64da_pkg::VALUE_WIDTH-1:0] shreg_reg;
    logic [u64da_pkg::VALUE_WIDTH-1:0] shreg_next;
    u64da_pkg::bit_cnt_t bit_cnt_reg;
    u64da_pkg::bit_cnt_t bit_cnt_next;
    u64da_pkg::count_t   count_reg;
    u64da_pkg::count_t   count_next;
    u64da_pkg::idx_t     idx_reg;
    u64da_pkg::idx_t     idx_next;

    u64da_pkg::cell_ctl_t ctl;
    logic                 carry [u64da_pkg::NUM_CELLS+1];
    u64da_pkg::bcd_t      digit [u64da_pkg::NUM_CELLS];
    u64da_pkg::count_t    ndig;
    logic                 accept;

    assign accept   = start && (state_reg == u64da_pkg::ST_IDLE);
    assign busy     = (state_reg != u64da_pkg::ST_IDLE);
    assign ctl.clear = accept;
    assign ctl.shift = (state_reg == u64da_pkg::ST_CONV);
    assign carry[0] = shreg_reg[u64da_pkg::VALUE_WIDTH-1];

    genvar g;
    generate
        for (g = 0; g < u64da_pkg::NUM_CELLS; g++)
        begin : g_cell
            u64da_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .carry_in  (carry[g]),
                .carry_out (carry[g+1]),
                .digit     (digit[g])
            );
        end
    endgenerate

    // highest nonzero digit, at least one digit, clamped to the limit
    always_comb
    begin
        ndig = u64da_pkg::count_t'(1);
        for (int i = 0; i < u64da_pkg::NUM_CELLS; i++)
        begin
            if (digit[i] != '0)
            begin
                ndig = u64da_pkg::count_t'(i + 1);
            end
        end
        if (ndig > u64da_pkg::count_t'(u64da_pkg::MAX_DIGITS))
        begin
            ndig = u64da_pkg::count_t'(u64da_pkg::MAX_DIGITS);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        shreg_next   = shreg_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        case (state_reg)
            u64da_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    shreg_next   = value[u64da_pkg::VALUE_WIDTH-1:0];
                    bit_cnt_next = '0;
                    state_next   = u64da_pkg::ST_CONV;
                end
            end
            u64da_pkg::ST_CONV:
            begin
                shreg_next   = shreg_reg << 1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == u64da_pkg::bit_cnt_t'(u64da_pkg::VALUE_WIDTH - 1))
                begin
                    state_next = u64da_pkg::ST_COUNT;
                end
            end
            u64da_pkg::ST_COUNT:
            begin
                count_next = ndig;
                idx_next   = u64da_pkg::idx_t'(ndig - 1'b1);
                state_next = u64da_pkg::ST_EMIT;
            end
            u64da_pkg::ST_EMIT:
            begin
                idx_next = idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = u64da_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = u64da_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= u64da_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shreg_reg <= shreg_next;
    end

    assign strobe      = (state_reg == u64da_pkg::ST_EMIT);
    assign digit_char  = u64da_pkg::ASCII_ZERO + {2'b00, digit[idx_reg]};
    assign digit_count = count_reg;
    assign is_last     = (idx_reg == '0);

endmodule
